/* design/gtc_pkg.sv */
package gtc_pkg;

   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int MAX_RADIUS = 7;

   localparam int CELLS   = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int XC_W    = $clog2(MAX_WIDTH);
   localparam int YC_W    = $clog2(MAX_HEIGHT);
   localparam int DIM_W   = 7;
   localparam int RAD_W   = 3;
   localparam int RSQ_W   = 7;
   localparam int OCC_W   = 17;
   localparam int ELEV_W  = 24;
   localparam int GRAD_W  = ELEV_W + 2;
   localparam int SLOPE_W = 52;
   localparam int CSR_IDX_W = 3;

   localparam logic [OCC_W-1:0] OCC_ONE = OCC_W'(65536);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_WIDTH  = 3'd0,
      CSR_GRID_HEIGHT = 3'd1,
      CSR_RADIUS      = 3'd2,
      CSR_RADIUS_SQ   = 3'd3,
      CSR_OCC_THRESH  = 3'd4,
      CSR_SLOPE_LIMIT = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      CLASS_UNKNOWN     = 2'd0,
      CLASS_BLOCKED     = 2'd1,
      CLASS_TRAVERSABLE = 2'd2
   } class_type;

   localparam logic OP_WRITE    = 1'b0;
   localparam logic OP_CLASSIFY = 1'b1;

   typedef struct packed {
      logic                     mark_occ;
      logic                     mark_elev;
      logic [OCC_W-1:0]         occ;
      logic signed [ELEV_W-1:0] elev;
   } cell_type;

   localparam int CELL_W = $bits(cell_type);

   typedef struct packed {
      logic [DIM_W-1:0] grid_width;
      logic [DIM_W-1:0] grid_height;
      logic [RAD_W-1:0] scan_radius;
      logic [RSQ_W-1:0] radius_sq_limit;
      logic [OCC_W-1:0] occ_threshold;
   } cfg_type;

   typedef struct packed {
      logic                     start;
      logic signed [GRAD_W-1:0] gx;
      logic signed [GRAD_W-1:0] gy;
   } slope_req_type;

   typedef struct packed {
      logic done;
      logic over;
   } slope_rsp_type;

endpackage

/* design/gtc_ram.sv */
module gtc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* design/gtc_slope.sv */
module gtc_slope (
   input  logic                         clock,
   input  logic                         reset,
   input  gtc_pkg::slope_req_type       req,
   input  logic [gtc_pkg::SLOPE_W-1:0]  limit,
   output gtc_pkg::slope_rsp_type       rsp
);

   logic                                  v0_ff, v1_ff, v2_ff, done_ff;
   logic signed [gtc_pkg::GRAD_W-1:0]     gx_ff, gy_ff;
   logic signed [2*gtc_pkg::GRAD_W-1:0]   px_full, py_full;
   logic [gtc_pkg::SLOPE_W-1:0]           px_ff, py_ff;
   logic                                  over_ff;

   // squares are non-negative and below 2^50
   assign px_full = gx_ff * gx_ff;
   assign py_full = gy_ff * gy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff   <= 1'b0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v0_ff   <= req.start;
         v1_ff   <= v0_ff;
         v2_ff   <= v1_ff;
         done_ff <= v2_ff;
      end
      if (req.start) begin
         gx_ff <= req.gx;
         gy_ff <= req.gy;
      end
      if (v0_ff) px_ff <= px_full[gtc_pkg::SLOPE_W-1:0];
      if (v1_ff) py_ff <= py_full[gtc_pkg::SLOPE_W-1:0];
      if (v2_ff) over_ff <= (px_ff + py_ff) > limit;
   end

   assign rsp.done = done_ff;
   assign rsp.over = over_ff;

endmodule

/* design/gtc_seq.sv */
module gtc_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  gtc_pkg::cfg_type                  cfg,
   input  logic                              start,
   output logic                              busy,
   input  logic                              opcode,
   input  logic [gtc_pkg::XC_W-1:0]          cell_x,
   input  logic [gtc_pkg::YC_W-1:0]          cell_y,
   input  logic [gtc_pkg::OCC_W-1:0]         occupancy,
   input  logic                              occupancy_ok,
   input  logic signed [gtc_pkg::ELEV_W-1:0] elevation,
   input  logic                              elevation_ok,
   output logic                              ram_we,
   output logic [gtc_pkg::ADDR_W-1:0]        ram_addr,
   output logic [gtc_pkg::CELL_W-1:0]        ram_wdata,
   input  logic [gtc_pkg::CELL_W-1:0]        ram_rdata,
   output gtc_pkg::slope_req_type            slope_req,
   input  gtc_pkg::slope_rsp_type            slope_rsp,
   output logic                              rsp_valid,
   output gtc_pkg::class_type                rsp_class
);

   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_CTR   = 9'b000000100,
      S_OFS   = 9'b000001000,
      S_OCHK  = 9'b000010000,
      S_NADR  = 9'b000100000,
      S_NCHK  = 9'b001000000,
      S_GRAD  = 9'b010000000,
      S_SLOPE = 9'b100000000
   } state_type;

   localparam int CO_W = 8;   // signed coordinate with offset
   localparam int OF_W = gtc_pkg::RAD_W + 1;

   state_type                           state_ff, state_in;
   logic [gtc_pkg::ADDR_W-1:0]          clr_ff, clr_in;
   logic [gtc_pkg::XC_W-1:0]            x_ff, x_in;
   logic [gtc_pkg::YC_W-1:0]            y_ff, y_in;
   logic signed [OF_W-1:0]              dx_ff, dx_in, dy_ff, dy_in;
   logic [1:0]                          k_ff, k_in;
   logic [3:0]                          has_ff, has_in;
   logic signed [gtc_pkg::ELEV_W-1:0]   ce_ff, ce_in;
   logic signed [gtc_pkg::ELEV_W-1:0]   ne_ff [4];
   logic signed [gtc_pkg::ELEV_W-1:0]   ne_in [4];
   logic                                rsp_valid_ff, rsp_valid_in;
   gtc_pkg::class_type                  rsp_class_ff, rsp_class_in;

   logic [gtc_pkg::DIM_W-1:0]           w_eff, h_eff;
   logic [gtc_pkg::RAD_W-1:0]           r_eff;
   logic signed [OF_W-1:0]              r_pos, r_neg;
   logic signed [CO_W-1:0]              dx_w, dy_w;
   logic [7:0]                          dist_sq;
   logic                                in_disk, last_ofs;
   logic signed [CO_W-1:0]              nx, ny;
   logic                                off_grid;
   gtc_pkg::cell_type                   rd, wr;
   logic [3:0]                          n_inside;
   logic signed [gtc_pkg::GRAD_W-1:0]   gx, gy;

   function automatic logic [gtc_pkg::ADDR_W-1:0] addr_of(
      input logic [gtc_pkg::XC_W-1:0] ax,
      input logic [gtc_pkg::YC_W-1:0] ay
   );
      addr_of = gtc_pkg::ADDR_W'(ay) * gtc_pkg::ADDR_W'(gtc_pkg::MAX_WIDTH)
                + gtc_pkg::ADDR_W'(ax);
   endfunction

   function automatic logic signed [gtc_pkg::GRAD_W-1:0] ext(
      input logic signed [gtc_pkg::ELEV_W-1:0] v
   );
      ext = gtc_pkg::GRAD_W'(v);
   endfunction

   assign w_eff = (cfg.grid_width > gtc_pkg::DIM_W'(gtc_pkg::MAX_WIDTH))
                  ? gtc_pkg::DIM_W'(gtc_pkg::MAX_WIDTH) : cfg.grid_width;
   assign h_eff = (cfg.grid_height > gtc_pkg::DIM_W'(gtc_pkg::MAX_HEIGHT))
                  ? gtc_pkg::DIM_W'(gtc_pkg::MAX_HEIGHT) : cfg.grid_height;
   assign r_eff = (cfg.scan_radius > gtc_pkg::RAD_W'(gtc_pkg::MAX_RADIUS))
                  ? gtc_pkg::RAD_W'(gtc_pkg::MAX_RADIUS) : cfg.scan_radius;
   assign r_pos = $signed({1'b0, r_eff});
   assign r_neg = -r_pos;

   // offsets widened before squaring so the products keep every bit
   assign dx_w     = CO_W'(dx_ff);
   assign dy_w     = CO_W'(dy_ff);
   assign dist_sq  = 8'(dx_w * dx_w + dy_w * dy_w);
   assign in_disk  = dist_sq <= {1'b0, cfg.radius_sq_limit};
   assign last_ofs = (dx_ff == r_pos) && (dy_ff == r_pos);
   assign nx = $signed({2'b00, x_ff}) + dx_w;
   assign ny = $signed({2'b00, y_ff}) + dy_w;
   assign off_grid = (nx < 0) || (ny < 0) ||
                     (nx >= $signed({1'b0, w_eff})) || (ny >= $signed({1'b0, h_eff}));

   assign rd = gtc_pkg::cell_type'(ram_rdata);

   assign n_inside[0] = x_ff != '0;
   assign n_inside[1] = ({1'b0, x_ff} + 7'd1) < w_eff;
   assign n_inside[2] = y_ff != '0;
   assign n_inside[3] = ({1'b0, y_ff} + 7'd1) < h_eff;

   always_comb begin
      if (has_ff[0] && has_ff[1]) gx = ext(ne_ff[1]) - ext(ne_ff[0]);
      else if (has_ff[1])         gx = (ext(ne_ff[1]) - ext(ce_ff)) <<< 1;
      else                        gx = (ext(ce_ff) - ext(ne_ff[0])) <<< 1;
      if (has_ff[2] && has_ff[3]) gy = ext(ne_ff[3]) - ext(ne_ff[2]);
      else if (has_ff[3])         gy = (ext(ne_ff[3]) - ext(ce_ff)) <<< 1;
      else                        gy = (ext(ce_ff) - ext(ne_ff[2])) <<< 1;
   end

   always_comb begin
      wr.mark_occ  = occupancy_ok && (occupancy <= gtc_pkg::OCC_ONE);
      wr.mark_elev = elevation_ok;
      wr.occ       = occupancy;
      wr.elev      = elevation;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      k_in         = k_ff;
      has_in       = has_ff;
      ce_in        = ce_ff;
      ne_in        = ne_ff;
      rsp_valid_in = 1'b0;
      rsp_class_in = rsp_class_ff;
      ram_we       = 1'b0;
      ram_addr     = addr_of(x_ff, y_ff);
      ram_wdata    = '0;
      slope_req.start = 1'b0;
      slope_req.gx    = gx;
      slope_req.gy    = gy;
      case (state_ff)
         S_CLEAR: begin
            ram_we   = 1'b1;
            ram_addr = clr_ff;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == gtc_pkg::ADDR_W'(gtc_pkg::CELLS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               ram_addr = addr_of(cell_x, cell_y);
               if (opcode == gtc_pkg::OP_WRITE) begin
                  ram_we    = 1'b1;
                  ram_wdata = wr;
               end else if ({1'b0, cell_x} >= w_eff || {1'b0, cell_y} >= h_eff) begin
                  rsp_valid_in = 1'b1;
                  rsp_class_in = gtc_pkg::CLASS_UNKNOWN;
               end else begin
                  x_in     = cell_x;
                  y_in     = cell_y;
                  state_in = S_CTR;
               end
            end
         end
         S_CTR: begin
            ce_in = rd.elev;
            dx_in = r_neg;
            dy_in = r_neg;
            if (!(rd.mark_occ && rd.mark_elev)) begin
               rsp_valid_in = 1'b1;
               rsp_class_in = gtc_pkg::CLASS_UNKNOWN;
               state_in     = S_IDLE;
            end else begin
               state_in = S_OFS;
            end
         end
         S_OFS, S_OCHK: begin
            logic advance;
            advance = 1'b0;
            if (state_ff == S_OFS) begin
               if (!in_disk) begin
                  advance = 1'b1;
               end else if (off_grid) begin
                  rsp_valid_in = 1'b1;
                  rsp_class_in = gtc_pkg::CLASS_UNKNOWN;
                  state_in     = S_IDLE;
               end else begin
                  ram_addr = addr_of(nx[gtc_pkg::XC_W-1:0], ny[gtc_pkg::YC_W-1:0]);
                  state_in = S_OCHK;
               end
            end else if (!(rd.mark_occ && rd.mark_elev)) begin
               rsp_valid_in = 1'b1;
               rsp_class_in = gtc_pkg::CLASS_UNKNOWN;
               state_in     = S_IDLE;
            end else if (rd.occ >= cfg.occ_threshold) begin
               rsp_valid_in = 1'b1;
               rsp_class_in = gtc_pkg::CLASS_BLOCKED;
               state_in     = S_IDLE;
            end else begin
               advance = 1'b1;
            end
            if (advance) begin
               if (last_ofs) begin
                  k_in     = 2'd0;
                  state_in = S_NADR;
               end else begin
                  state_in = S_OFS;
                  if (dx_ff == r_pos) begin
                     dx_in = r_neg;
                     dy_in = dy_ff + 1'b1;
                  end else begin
                     dx_in = dx_ff + 1'b1;
                  end
               end
            end
         end
         S_NADR: begin
            case (k_ff)
               2'd0:    ram_addr = addr_of(x_ff - 1'b1, y_ff);
               2'd1:    ram_addr = addr_of(x_ff + 1'b1, y_ff);
               2'd2:    ram_addr = addr_of(x_ff, y_ff - 1'b1);
               default: ram_addr = addr_of(x_ff, y_ff + 1'b1);
            endcase
            if (n_inside[k_ff]) begin
               state_in = S_NCHK;
            end else begin
               has_in[k_ff] = 1'b0;
               k_in = k_ff + 1'b1;
               if (k_ff == 2'd3) state_in = S_GRAD;
            end
         end
         S_NCHK: begin
            has_in[k_ff] = rd.mark_elev;
            ne_in[k_ff]  = rd.elev;
            k_in = k_ff + 1'b1;
            state_in = (k_ff == 2'd3) ? S_GRAD : S_NADR;
         end
         S_GRAD: begin
            if (!(has_ff[0] || has_ff[1]) || !(has_ff[2] || has_ff[3])) begin
               rsp_valid_in = 1'b1;
               rsp_class_in = gtc_pkg::CLASS_UNKNOWN;
               state_in     = S_IDLE;
            end else begin
               slope_req.start = 1'b1;
               state_in        = S_SLOPE;
            end
         end
         S_SLOPE: begin
            if (slope_rsp.done) begin
               rsp_valid_in = 1'b1;
               rsp_class_in = slope_rsp.over ? gtc_pkg::CLASS_BLOCKED
                                             : gtc_pkg::CLASS_TRAVERSABLE;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff         <= x_in;
      y_ff         <= y_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      has_ff       <= has_in;
      ce_ff        <= ce_in;
      ne_ff        <= ne_in;
      rsp_class_ff <= rsp_class_in;
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_class = rsp_class_ff;

`ifndef ASSERT_OFF
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !rsp_valid_ff)
      else $error("response during clearing pass");
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OFS || state_ff == S_OCHK || state_ff == S_NADR ||
       state_ff == S_NCHK) |-> !ram_we)
      else $error("cell store written during classify");
   a_classify_moves: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && opcode == gtc_pkg::OP_CLASSIFY)
      |=> (rsp_valid_ff || state_ff == S_CTR))
      else $error("classify word lost");
   a_slope_done_state: assert property (@(posedge clock) disable iff (reset)
      slope_rsp.done |-> state_ff == S_SLOPE)
      else $error("slope result outside wait state");
`endif

endmodule

/* design/grid_traversability_classifier_core.sv */
// Grid traversability classifier. After reset the block clears its 4096-entry cell
// store, one entry per cycle, and holds busy high until the clearing pass ends; csr
// writes are taken throughout. A write word goes to the store in the cycle it is
// accepted. A classify word runs the accept and the center check, then walks the
// (2r+1)^2 scan square with one store read for each offset inside the disk
// (registered read data), then reads up to four gradient neighbors and hands the
// slope squares and compare to the slope unit. While a scan runs busy stays high,
// and a new word is taken only when idle. The store's single port allows one read
// at a time. A scan that hits an unknown or blocked cell, or an off-grid cell in
// the disk, ends early.
// A result is shown on rsp_cell_class for one cycle with rsp_valid and must be taken
// then: there is no back-pressure. Write words produce no result.
module grid_traversability_classifier_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_opcode,
   input  logic [gtc_pkg::XC_W-1:0]              req_cell_x,
   input  logic [gtc_pkg::YC_W-1:0]              req_cell_y,
   input  logic [gtc_pkg::OCC_W-1:0]             req_occupancy,
   input  logic                                  req_occupancy_ok,
   input  logic signed [gtc_pkg::ELEV_W-1:0]     req_elevation,
   input  logic                                  req_elevation_ok,
   output logic                                  rsp_valid,
   output logic [1:0]                            rsp_cell_class,
   input  logic                                  csr_we,
   input  logic [gtc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [gtc_pkg::SLOPE_W-1:0]           csr_wdata
);

   gtc_pkg::cfg_type              cfg_ff;
   logic [gtc_pkg::SLOPE_W-1:0]   slope_lim_ff;
   logic                          ram_we;
   logic [gtc_pkg::ADDR_W-1:0]    ram_addr;
   logic [gtc_pkg::CELL_W-1:0]    ram_wdata, ram_rdata;
   gtc_pkg::slope_req_type        slope_req;
   gtc_pkg::slope_rsp_type        slope_rsp;
   gtc_pkg::class_type            rsp_class;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width      <= gtc_pkg::DIM_W'(64);
         cfg_ff.grid_height     <= gtc_pkg::DIM_W'(64);
         cfg_ff.scan_radius     <= gtc_pkg::RAD_W'(2);
         cfg_ff.radius_sq_limit <= gtc_pkg::RSQ_W'(4);
         cfg_ff.occ_threshold   <= gtc_pkg::OCC_W'(32768);
         slope_lim_ff           <= gtc_pkg::SLOPE_W'(1000000);
      end else if (csr_we) begin
         case (csr_index)
            gtc_pkg::CSR_GRID_WIDTH:
               cfg_ff.grid_width <= csr_wdata[gtc_pkg::DIM_W-1:0];
            gtc_pkg::CSR_GRID_HEIGHT:
               cfg_ff.grid_height <= csr_wdata[gtc_pkg::DIM_W-1:0];
            gtc_pkg::CSR_RADIUS:
               cfg_ff.scan_radius <= csr_wdata[gtc_pkg::RAD_W-1:0];
            gtc_pkg::CSR_RADIUS_SQ:
               cfg_ff.radius_sq_limit <= csr_wdata[gtc_pkg::RSQ_W-1:0];
            gtc_pkg::CSR_OCC_THRESH:
               cfg_ff.occ_threshold <= csr_wdata[gtc_pkg::OCC_W-1:0];
            gtc_pkg::CSR_SLOPE_LIMIT:
               slope_lim_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   gtc_ram #(
      .WIDTH (gtc_pkg::CELL_W),
      .DEPTH (gtc_pkg::CELLS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   gtc_slope u_slope (
      .clock (clock),
      .reset (reset),
      .req   (slope_req),
      .limit (slope_lim_ff),
      .rsp   (slope_rsp)
   );

   gtc_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .start        (start),
      .busy         (busy),
      .opcode       (req_opcode),
      .cell_x       (req_cell_x),
      .cell_y       (req_cell_y),
      .occupancy    (req_occupancy),
      .occupancy_ok (req_occupancy_ok),
      .elevation    (req_elevation),
      .elevation_ok (req_elevation_ok),
      .ram_we       (ram_we),
      .ram_addr     (ram_addr),
      .ram_wdata    (ram_wdata),
      .ram_rdata    (ram_rdata),
      .slope_req    (slope_req),
      .slope_rsp    (slope_rsp),
      .rsp_valid    (rsp_valid),
      .rsp_class    (rsp_class)
   );

   assign rsp_cell_class = rsp_class;

endmodule
